// ===== sv/gradient_noise_octave_sampler_assert.svh =====
// Assertion macros used by the sampler's controller.
// Both expect signals named clock and reset in the scope of use.
`ifndef GRADIENT_NOISE_OCTAVE_SAMPLER_ASSERT_SVH
`define GRADIENT_NOISE_OCTAVE_SAMPLER_ASSERT_SVH

// Same-cycle implication.
`define GNOS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gnos assertion failed");

// Next-cycle implication.
`define GNOS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gnos assertion failed");

`endif

// ===== sv/gnos_pkg.sv =====
package gnos_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int POS_W      = 24;
   localparam int TBL_W      = 8;
   localparam int VAL_W      = 24;
   localparam int MUL_W      = 25;
   localparam int ACC_W      = 32;
   localparam int AMP_W      = 20;
   localparam int GREY_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_DIMENSIONS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_COUNT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_AMPLITUDE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_COORD        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_W_COORD        = 3'd4;

   typedef struct packed {
      logic             req_type;
      logic [7:0]       table_index;
      logic [7:0]       table_value;
      logic [POS_W-1:0] coord_x;
      logic [POS_W-1:0] coord_y;
   } req_item_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] noise_value;
      logic [GREY_W-1:0]       grey_byte;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0]       dimensions;
      logic [3:0]       octave_count;
      logic [AMP_W-1:0] base_amplitude;
      logic [POS_W-1:0] z_coord;
      logic [POS_W-1:0] w_coord;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_START, OP_FADE1, OP_FADE2, OP_FADE3, OP_FADE4,
      OP_HASH_FIRST, OP_HASH_NEXT, OP_GRAD, OP_BL_RD, OP_BL_MUL, OP_BL_WR,
      OP_ACC_MUL, OP_ACC_ADD, OP_FINISH
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FADE1, ST_FADE2, ST_FADE3, ST_FADE4, ST_H_ISSUE, ST_H_STEP,
      ST_B_RD, ST_B_MUL, ST_B_WR, ST_ACC_MUL, ST_ACC_ADD, ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] axis;
      logic [3:0] corner;
      logic [1:0] dsel;
   } dp_cmd_type;

   typedef struct packed {
      logic rsp_pending;
   } dp_status_type;

   // Gradient dot product for one lattice corner; dsel is the axis count minus one.
   function automatic logic signed [VAL_W-1:0] grad_value(
      input logic [1:0] dsel, input logic [TBL_W-1:0] h,
      input logic signed [VAL_W-1:0] o0, input logic signed [VAL_W-1:0] o1,
      input logic signed [VAL_W-1:0] o2, input logic signed [VAL_W-1:0] o3);
      logic signed [VAL_W-1:0] u;
      logic signed [VAL_W-1:0] w;
      logic signed [VAL_W-1:0] t;
      logic signed [VAL_W-1:0] g;
      logic [4:0]              h5;
      h5 = h[4:0];
      u = o0;
      w = o1;
      t = o2;
      g = '0;
      case (dsel)
         2'd0: begin
            g = $signed(VAL_W'(h[2:0])) + $signed(VAL_W'(1));
            g = VAL_W'(g * o0);
            if (h[3]) g = -g;
         end
         2'd1: begin
            if (h[2]) begin
               u = o1;
               w = o0;
            end
            if (h[0]) u = -u;
            if (h[1]) w = -w;
            g = u + (w <<< 1);
         end
         2'd2: begin
            u = h[3] ? o1 : o0;
            if (h[2]) w = (h[3:0] >= 4'd12) ? o0 : o2;
            else w = o1;
            if (h[0]) u = -u;
            if (h[1]) w = -w;
            g = u + w;
         end
         default: begin
            u = (h5 < 5'd24) ? o0 : o1;
            w = (h5 < 5'd16) ? o1 : o2;
            t = (h5 < 5'd8) ? o2 : o3;
            if (h[0]) u = -u;
            if (h[1]) w = -w;
            if (h[2]) t = -t;
            g = u + w + t;
         end
      endcase
      return g;
   endfunction

endpackage

// ===== sv/gradient_noise_octave_sampler.sv =====
// Gradient noise octave sampler.
// Input channel (req_*): a beat with req_type load writes one byte of the
// 256-entry permutation table and returns nothing; a beat with req_type
// sample carries a Q8.16 x/y position and returns exactly one rsp_ beat.
// Result channel (rsp_*): a signed Q8.16 octave sum, saturated, and a grey
// byte derived from it. Configuration (csr_*) is written one register per
// cycle; the user must write it only while the block is idle, as the block
// itself does not enforce this. There is no read-back.
// A sample's run time is set by one shared multiplier for the fade, blend
// and amplitude steps and by the chained single-port table lookups, one per
// cycle, for every corner.
// One sample is worked on at a time; req_ready is high only while idle.
// A finished result sits in an output register, so the next beat is taken
// while the receiver stalls; a second result waits until rsp_ready frees it.
// Reset clears the control state and loads the configuration defaults;
// the permutation table is not cleared and must be loaded before use.
module gradient_noise_octave_sampler #(
   parameter int MAX_OCTAVES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  gnos_pkg::req_item_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output gnos_pkg::rsp_item_type          rsp_data,
   input  logic                            csr_write_enable,
   input  logic [gnos_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gnos_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import gnos_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // Configuration registers.
   gnos_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Sequencer: walks fades, corner hashes, blends and the octave sum.
   gnos_ctrl #(
      .MAX_OCTAVES (MAX_OCTAVES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.req_type),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .cfg       (cfg),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: table, corner value store, shared multiplier, output register.
   gnos_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .cfg       (cfg),
      .rsp_ready (rsp_ready),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/gnos_csr.sv =====
module gnos_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [gnos_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gnos_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output gnos_pkg::cfg_type                 cfg
);
   import gnos_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DIMENSIONS:     cfg_in.dimensions     = csr_write_data[2:0];
            CSR_OCTAVE_COUNT:   cfg_in.octave_count   = csr_write_data[3:0];
            CSR_BASE_AMPLITUDE: cfg_in.base_amplitude = csr_write_data[AMP_W-1:0];
            CSR_Z_COORD:        cfg_in.z_coord        = csr_write_data[POS_W-1:0];
            CSR_W_COORD:        cfg_in.w_coord        = csr_write_data[POS_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dimensions     <= 3'd2;
         cfg_ff.octave_count   <= 4'd1;
         cfg_ff.base_amplitude <= AMP_W'(1 << FRAC_BITS);
         cfg_ff.z_coord        <= '0;
         cfg_ff.w_coord        <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/gnos_dp.sv =====
module gnos_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  gnos_pkg::dp_cmd_type   cmd,
   input  gnos_pkg::req_item_type req_data,
   input  gnos_pkg::cfg_type      cfg,
   input  logic                   rsp_ready,
   output gnos_pkg::dp_status_type status,
   output logic                   rsp_valid,
   output gnos_pkg::rsp_item_type rsp_data
);
   import gnos_pkg::*;

   localparam int NUM_CELLS = 1 << TBL_W;

   logic [TBL_W-1:0]        perm_mem [NUM_CELLS];
   logic signed [VAL_W-1:0] val_mem  [16];
   logic [POS_W-1:0]        pos_ff   [4];
   logic signed [MUL_W-1:0] s_ff     [4];

   logic [TBL_W-1:0]        rd_ff;
   logic signed [VAL_W-1:0] ra_ff, rb_ff, noise_ff;
   logic signed [MUL_W-1:0] f2_ff;
   logic signed [ACC_W-1:0] mul_ff, sum_ff;
   logic [AMP_W-1:0]        amp_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_item_type            rsp_data_ff;

   logic [FRAC_BITS-1:0]        frac;
   logic signed [MUL_W-1:0]     f_ext, inner, mul_a, mul_b;
   logic signed [2*MUL_W-1:0]   product;
   logic [TBL_W-1:0]            hash_addr;
   logic signed [VAL_W-1:0]     off [4];
   logic signed [VAL_W-1:0]     blend_w, sat;
   logic signed [VAL_W:0]       q;
   logic [GREY_W-1:0]           grey;

   assign frac  = pos_ff[cmd.axis][FRAC_BITS-1:0];
   assign f_ext = $signed(MUL_W'(frac));
   assign inner = MUL_W'(f2_ff * 6) - MUL_W'(f_ext * 15) + $signed(MUL_W'(10 << FRAC_BITS));

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_FADE1: begin
            mul_a = f_ext;
            mul_b = f_ext;
         end
         OP_FADE2: begin
            mul_a = mul_ff[MUL_W-1:0];
            mul_b = f_ext;
         end
         OP_FADE3: begin
            mul_a = mul_ff[MUL_W-1:0];
            mul_b = inner;
         end
         OP_BL_MUL: begin
            mul_a = s_ff[cmd.axis];
            mul_b = {rb_ff[VAL_W-1], rb_ff} - {ra_ff[VAL_W-1], ra_ff};
         end
         OP_ACC_MUL: begin
            mul_a = $signed(MUL_W'(amp_ff));
            mul_b = {noise_ff[VAL_W-1], noise_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Dropping the low FRAC_BITS bits of this product (in mul_ff) gives the floor of the scaled product.
   assign product = mul_a * mul_b;

   always_comb begin
      hash_addr = pos_ff[cmd.axis][POS_W-1 -: TBL_W] + TBL_W'(cmd.corner[cmd.axis]);
      if (cmd.op == OP_HASH_NEXT) hash_addr = hash_addr + rd_ff;
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         off[k] = $signed(VAL_W'(pos_ff[k][FRAC_BITS-1:0]))
                - (cmd.corner[k] ? $signed(VAL_W'(1 << FRAC_BITS)) : $signed(VAL_W'(0)));
      end
   end

   assign blend_w = ra_ff + mul_ff[VAL_W-1:0];

   always_comb begin
      if (sum_ff > $signed(ACC_W'(8388607))) sat = 24'sh7FFFFF;
      else if (sum_ff < -$signed(ACC_W'(8388608))) sat = 24'sh800000;
      else sat = sum_ff[VAL_W-1:0];
      q = {sat[VAL_W-1], sat} + $signed((VAL_W + 1)'(1 << FRAC_BITS));
      if (q <= 0) grey = '0;
      else if (q[VAL_W:FRAC_BITS-7] > 255) grey = 8'd255;
      else grey = q[FRAC_BITS:FRAC_BITS-7];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) perm_mem[req_data.table_index] <= req_data.table_value;
      if (cmd.op == OP_HASH_FIRST || cmd.op == OP_HASH_NEXT) rd_ff <= perm_mem[hash_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_GRAD) begin
         val_mem[cmd.corner] <= grad_value(cmd.dsel, rd_ff, off[0], off[1], off[2], off[3]);
      end else if (cmd.op == OP_BL_WR) begin
         val_mem[cmd.corner] <= blend_w;
      end
      if (cmd.op == OP_BL_RD) begin
         ra_ff <= val_mem[cmd.corner];
         rb_ff <= val_mem[cmd.corner | (4'd1 << cmd.axis)];
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= product[FRAC_BITS + ACC_W - 1:FRAC_BITS];
      case (cmd.op)
         OP_START: begin
            pos_ff[0] <= req_data.coord_x;
            pos_ff[1] <= req_data.coord_y;
            pos_ff[2] <= cfg.z_coord;
            pos_ff[3] <= cfg.w_coord;
            amp_ff    <= cfg.base_amplitude;
            sum_ff    <= '0;
         end
         OP_FADE2: f2_ff <= mul_ff[MUL_W-1:0];
         OP_FADE4: s_ff[cmd.axis] <= mul_ff[MUL_W-1:0];
         OP_BL_WR: noise_ff <= blend_w;
         OP_ACC_ADD: begin
            sum_ff <= sum_ff + mul_ff;
            for (int k = 0; k < 4; k++) pos_ff[k] <= {pos_ff[k][POS_W-2:0], 1'b0};
            amp_ff <= amp_ff >> 1;
         end
         OP_FINISH: begin
            rsp_data_ff.noise_value <= sat;
            rsp_data_ff.grey_byte   <= grey;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == OP_FINISH) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   assign status.rsp_pending = rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/gnos_ctrl.sv =====
`include "gradient_noise_octave_sampler_assert.svh"

module gnos_ctrl #(
   parameter int MAX_OCTAVES = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_kind,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   input  gnos_pkg::cfg_type       cfg,
   input  gnos_pkg::dp_status_type status,
   output gnos_pkg::dp_cmd_type    cmd
);
   import gnos_pkg::*;

   localparam int OW = (MAX_OCTAVES < 2) ? 1 : $clog2(MAX_OCTAVES + 1);

   ctrl_state_type state_ff, state_in;
   logic [1:0]     axis_ff, axis_in;
   logic [3:0]     corner_ff, corner_in;
   logic [1:0]     hk_ff, hk_in;
   logic [OW-1:0]  oct_ff, oct_in;

   logic [1:0]     dsel;
   logic [OW-1:0]  oct_eff;
   logic [3:0]     last_corner, half_last;

   always_comb begin
      if (cfg.dimensions == 3'd0) dsel = 2'd0;
      else if (cfg.dimensions > 3'd4) dsel = 2'd3;
      else dsel = 2'(cfg.dimensions - 3'd1);
      if (cfg.octave_count == 4'd0) oct_eff = OW'(1);
      else if (32'(cfg.octave_count) > MAX_OCTAVES) oct_eff = OW'(MAX_OCTAVES);
      else oct_eff = OW'(cfg.octave_count);
   end

   assign last_corner = 4'((5'd2 << dsel) - 5'd1);
   assign half_last   = 4'((5'd1 << axis_ff) - 5'd1);

   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      corner_in  = corner_ff;
      hk_in      = hk_ff;
      oct_in     = oct_ff;
      req_ready  = 1'b0;
      cmd.op     = OP_NONE;
      cmd.axis   = axis_ff;
      cmd.corner = corner_ff;
      cmd.dsel   = dsel;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == REQ_LOAD) begin
                  cmd.op = OP_LOAD;
               end else begin
                  cmd.op   = OP_START;
                  axis_in  = '0;
                  oct_in   = '0;
                  state_in = ST_FADE1;
               end
            end
         end
         ST_FADE1: begin
            cmd.op   = OP_FADE1;
            state_in = ST_FADE2;
         end
         ST_FADE2: begin
            cmd.op   = OP_FADE2;
            state_in = ST_FADE3;
         end
         ST_FADE3: begin
            cmd.op   = OP_FADE3;
            state_in = ST_FADE4;
         end
         ST_FADE4: begin
            cmd.op = OP_FADE4;
            if (axis_ff == dsel) begin
               corner_in = '0;
               state_in  = ST_H_ISSUE;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_FADE1;
            end
         end
         ST_H_ISSUE: begin
            cmd.op   = OP_HASH_FIRST;
            cmd.axis = dsel;
            hk_in    = dsel;
            state_in = ST_H_STEP;
         end
         ST_H_STEP: begin
            if (hk_ff != 2'd0) begin
               cmd.op   = OP_HASH_NEXT;
               cmd.axis = hk_ff - 2'd1;
               hk_in    = hk_ff - 2'd1;
            end else begin
               cmd.op = OP_GRAD;
               if (corner_ff == last_corner) begin
                  axis_in   = dsel;
                  corner_in = '0;
                  state_in  = ST_B_RD;
               end else begin
                  corner_in = corner_ff + 4'd1;
                  state_in  = ST_H_ISSUE;
               end
            end
         end
         ST_B_RD: begin
            cmd.op   = OP_BL_RD;
            state_in = ST_B_MUL;
         end
         ST_B_MUL: begin
            cmd.op   = OP_BL_MUL;
            state_in = ST_B_WR;
         end
         ST_B_WR: begin
            cmd.op = OP_BL_WR;
            if (corner_ff == half_last) begin
               corner_in = '0;
               if (axis_ff == 2'd0) begin
                  state_in = ST_ACC_MUL;
               end else begin
                  axis_in  = axis_ff - 2'd1;
                  state_in = ST_B_RD;
               end
            end else begin
               corner_in = corner_ff + 4'd1;
               state_in  = ST_B_RD;
            end
         end
         ST_ACC_MUL: begin
            cmd.op   = OP_ACC_MUL;
            state_in = ST_ACC_ADD;
         end
         ST_ACC_ADD: begin
            cmd.op = OP_ACC_ADD;
            if (OW'(oct_ff + 1'b1) == oct_eff) begin
               state_in = ST_FINISH;
            end else begin
               oct_in   = OW'(oct_ff + 1'b1);
               axis_in  = '0;
               state_in = ST_FADE1;
            end
         end
         ST_FINISH: begin
            if (!status.rsp_pending || rsp_ready) begin
               cmd.op   = OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         axis_ff   <= '0;
         corner_ff <= '0;
         hk_ff     <= '0;
         oct_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         axis_ff   <= axis_in;
         corner_ff <= corner_in;
         hk_ff     <= hk_in;
         oct_ff    <= oct_in;
      end
   end

   `GNOS_ASSERT_NXT(a_sample_starts_fade, state_ff == ST_IDLE && req_valid && req_kind == REQ_SAMPLE, state_ff == ST_FADE1)
   `GNOS_ASSERT_IMP(a_corner_in_range, state_ff == ST_H_STEP, corner_ff <= last_corner)
   `GNOS_ASSERT_IMP(a_blend_axis_in_range, state_ff == ST_B_RD, axis_ff <= dsel && corner_ff <= half_last)
   `GNOS_ASSERT_IMP(a_finish_has_room, cmd.op == OP_FINISH, !status.rsp_pending || rsp_ready)

endmodule
